// File: src/xs128_pkg.sv
package xs128_pkg;

  // Function codes on the input beat
  localparam logic [2:0] FuncSeed  = 3'd0;
  localparam logic [2:0] FuncRaw   = 3'd1;
  localparam logic [2:0] FuncBits31 = 3'd2;
  localparam logic [2:0] FuncBound = 3'd3;
  localparam logic [2:0] FuncBool  = 3'd4;
  localparam logic [2:0] FuncRange = 3'd5;

  // Generator reset and seeding constants
  localparam logic [31:0] InitX = 32'd123456789;
  localparam logic [31:0] InitY = 32'd362436069;
  localparam logic [31:0] InitZ = 32'd521288629;
  localparam logic [49:0] InitW = 50'd88675123;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Remainder unit: one quotient bit per cycle over a 31-bit dividend
  localparam int DivSteps = 31;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [2:0] {
    OP_SEED,
    OP_RAW,
    OP_BITS31,
    OP_BOUND,
    OP_BOOL,
    OP_RANGE,
    OP_NOP
  } op_e;

  // One classified item as it travels through the queue
  typedef struct packed {
    op_e         op;
    logic [31:0] seed;
    logic [31:0] start;
    logic [32:0] div_mag;
    logic        div_zero;
  } item_t;

endpackage

// File: src/xs128_front.sv
module xs128_front (
  input  logic               in_valid_i,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] new_seed_i,
  input  logic signed [31:0] bound_i,
  input  logic signed [31:0] range_start_i,
  input  logic signed [31:0] range_end_i,
  input  logic               q_full_i,
  output logic               in_stall_o,
  output logic               push_o,
  output xs128_pkg::item_t   item_o
);
  import xs128_pkg::*;

  logic [33:0] div_s;
  logic [33:0] div_neg;

  // Signed divisor: the bound, or end + 1 - start at 34 bits
  always_comb begin
    if (func_i == FuncRange) begin
      div_s = {{2{range_end_i[31]}}, range_end_i} + 34'd1
            - {{2{range_start_i[31]}}, range_start_i};
    end else begin
      div_s = {{2{bound_i[31]}}, bound_i};
    end
    div_neg = 34'd0 - div_s;
  end

  // Decode the function code and build the queued item
  always_comb begin
    item_o.op = OP_NOP;
    case (func_i)
      FuncSeed:   item_o.op = OP_SEED;
      FuncRaw:    item_o.op = OP_RAW;
      FuncBits31: item_o.op = OP_BITS31;
      FuncBound:  item_o.op = OP_BOUND;
      FuncBool:   item_o.op = OP_BOOL;
      FuncRange:  item_o.op = OP_RANGE;
      default:    item_o.op = OP_NOP;
    endcase
    item_o.seed     = new_seed_i;
    item_o.start    = (func_i == FuncRange) ? range_start_i : 32'd0;
    item_o.div_mag  = div_s[33] ? div_neg[32:0] : div_s[32:0];
    item_o.div_zero = (div_s == 34'd0);
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

// File: src/xs128_fifo.sv
module xs128_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xs128_pkg::item_t item_i,
  input  logic             pop_i,
  output xs128_pkg::item_t item_o,
  output logic             full_o,
  output logic             empty_o
);
  import xs128_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: src/xs128_back.sv
module xs128_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xs128_pkg::item_t   item_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [33:0] value_o,
  output logic               error_o
);
  import xs128_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [31:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [49:0] w_q, w_d;

  logic [30:0]        rem_q, rem_d, dvd_q, dvd_d;
  logic [32:0]        dmag_q, dmag_d;
  logic [31:0]        start_q, start_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d;
  logic [33:0]        value_q, value_d;
  logic               error_q, error_d;

  logic        out_free;
  logic [63:0] s64;
  logic [31:0] t, w_next;
  logic [31:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic [30:0] rem_n;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i && out_free;

  // Generator step and seed extension
  assign s64    = {{32{item_i.seed[31]}}, item_i.seed};
  assign t      = x_q ^ {x_q[20:0], 11'd0};
  assign w_next = w_q[31:0] ^ {1'b0, w_q[49:19]} ^ t ^ {8'd0, t[31:8]};

  // One restoring division step
  assign trial = {rem_q, dvd_q[30]};
  assign diff  = {1'b0, trial} - dmag_q;
  assign ge    = ({1'b0, trial} >= dmag_q);
  assign rem_n = ge ? diff[30:0] : trial[30:0];

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    w_d         = w_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    dmag_d      = dmag_q;
    start_d     = start_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;
    error_d     = error_q;

    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          out_valid_d = 1'b1;
          value_d     = '0;
          error_d     = 1'b0;
          // every draw advances the generator once
          if (item_i.op != OP_SEED && item_i.op != OP_NOP) begin
            x_d = y_q;
            y_d = z_q;
            z_d = w_q[31:0];
            w_d = {18'd0, w_next};
          end
          case (item_i.op)
            OP_SEED: begin
              x_d     = InitX ^ item_i.seed;
              y_d     = (InitY ^ {item_i.seed[14:0], 17'd0}) | {1'b0, s64[45:15]};
              z_d     = (InitZ ^ {item_i.seed[0], 31'd0}) | {1'b0, s64[31:1]};
              w_d     = (InitW ^ {item_i.seed, 18'd0}) | {19'd0, s64[44:14]};
              value_d = {{2{item_i.seed[31]}}, item_i.seed};
            end
            OP_RAW:    value_d = {2'b00, w_next};
            OP_BITS31: value_d = {3'b000, w_next[30:0]};
            OP_BOOL:   value_d = {33'd0, !w_next[0]};
            OP_BOUND, OP_RANGE: begin
              if (item_i.div_zero) begin
                error_d = 1'b1;
              end else begin
                // hand the draw to the remainder unit
                out_valid_d = 1'b0;
                rem_d       = '0;
                dvd_d       = w_next[30:0];
                dmag_d      = item_i.div_mag;
                start_d     = item_i.start;
                cnt_d       = '0;
                state_d     = ST_DIV;
              end
            end
            default: value_d = '0;
          endcase
        end
      end
      ST_DIV: begin
        rem_d = rem_n;
        dvd_d = {dvd_q[29:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          out_valid_d = 1'b1;
          value_d     = {{2{start_q[31]}}, start_q} + {3'b000, rem_n};
          error_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      x_q         <= InitX;
      y_q         <= InitY;
      z_q         <= InitZ;
      w_q         <= InitW;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      x_q         <= x_d;
      y_q         <= y_d;
      z_q         <= z_d;
      w_q         <= w_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    dmag_q  <= dmag_d;
    start_q <= start_d;
    value_q <= value_d;
    error_q <= error_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign error_o     = error_q;

endmodule

// File: src/xorshift128_random_source.sv
// Reseed, raw, 31-bit and boolean draws and zero-divisor errors pass through the queue
//   and the output register; bounded and range draws also pass through the remainder unit.
// Throughput: one beat per cycle for simple operations while the output is not stalled;
//   bounded and range draws hold the back end in the one-bit-per-cycle remainder unit.
// Reset (rst_ni, async, active low) loads the generator's default words and empties the
//   two-entry queue; no clearing pass.
module xorshift128_random_source (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] new_seed_i,
  input  logic signed [31:0] bound_i,
  input  logic signed [31:0] range_start_i,
  input  logic signed [31:0] range_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [33:0] value_o,
  output logic               error_o
);
  import xs128_pkg::*;

  item_t push_item, pop_item;
  logic  push, pop, q_full, q_empty;

  // Front: classify and compute divisor
  xs128_front u_front (
    .in_valid_i    (in_valid_i),
    .func_i        (func_i),
    .new_seed_i    (new_seed_i),
    .bound_i       (bound_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .q_full_i      (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .item_o        (push_item)
  );

  // Queue between front and back
  xs128_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: generator, remainder unit, output register
  xs128_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (pop_item),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .error_o     (error_o)
  );

endmodule

// File: src/xs128_checker.sv
module xs128_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [33:0] value_o,
  input logic               error_o
);

  // A stalled result beat stays valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_o) && $stable(error_o))
    else $error("result payload changed while stalled");

  // An error beat carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> value_o == 34'sd0)
    else $error("error beat with nonzero value");

  // Negative results never go below -2^31
  a_neg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_o[33] |-> value_o[32] && value_o[31])
    else $error("negative result out of range");

endmodule

bind xorshift128_random_source xs128_checker u_chk (.*);
